// ----- sv/psg_tone_noise_envelope_tick_defines.svh -----
// ----------------------------------------------------------------------------
// PSG assertion macros
// Shared concurrent assertion forms for the sound generator core. Each macro
// samples on i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PSG_TONE_NOISE_ENVELOPE_TICK_DEFINES_SVH
`define PSG_TONE_NOISE_ENVELOPE_TICK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTNE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTNE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ptne_pkg.sv -----
// ----------------------------------------------------------------------------
// PSG tone/noise/envelope package
// Beat types, sound register map, write masks, envelope shape codes and the
// amplitude level table of the three-voice sound generator core.
// ----------------------------------------------------------------------------
package ptne_pkg;

    // Input beat: a register write or one generator tick.
    typedef struct packed {
        logic       mode;
        logic [3:0] reg_number;
        logic [7:0] reg_value;
    } t_in_beat;

    // Output beat: one amplitude per channel.
    typedef struct packed {
        logic [15:0] amp_a;
        logic [15:0] amp_b;
        logic [15:0] amp_c;
    } t_out_beat;

    // Beat kinds carried in the mode field.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Sound register map.
    localparam int unsigned NUM_REGS = 14;
    localparam logic [3:0] REG_TONE_A_LO = 4'd0;
    localparam logic [3:0] REG_TONE_A_HI = 4'd1;
    localparam logic [3:0] REG_TONE_B_LO = 4'd2;
    localparam logic [3:0] REG_TONE_B_HI = 4'd3;
    localparam logic [3:0] REG_TONE_C_LO = 4'd4;
    localparam logic [3:0] REG_TONE_C_HI = 4'd5;
    localparam logic [3:0] REG_NOISE_PER = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_AMP_A     = 4'd8;
    localparam logic [3:0] REG_AMP_B     = 4'd9;
    localparam logic [3:0] REG_AMP_C     = 4'd10;
    localparam logic [3:0] REG_ENV_LO    = 4'd11;
    localparam logic [3:0] REG_ENV_HI    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    // Write masks.
    localparam logic [7:0] MASK_NIBBLE = 8'h0F;
    localparam logic [7:0] MASK_FIVE   = 8'h1F;
    localparam logic [7:0] MASK_SIX    = 8'h3F;

    // Envelope shape codes. The first two pairs bound ranges of shapes that
    // share one behavior.
    localparam logic [3:0] ENV_DECAY_FIRST  = 4'd0;
    localparam logic [3:0] ENV_DECAY_LAST   = 4'd3;
    localparam logic [3:0] ENV_ATTACK_FIRST = 4'd4;
    localparam logic [3:0] ENV_ATTACK_LAST  = 4'd7;
    localparam logic [3:0] ENV_SAW_DOWN     = 4'd8;
    localparam logic [3:0] ENV_DECAY_ALT    = 4'd9;
    localparam logic [3:0] ENV_TRI_DOWN     = 4'd10;
    localparam logic [3:0] ENV_DECAY_HIGH   = 4'd11;
    localparam logic [3:0] ENV_SAW_UP       = 4'd12;
    localparam logic [3:0] ENV_ATTACK_HOLD  = 4'd13;
    localparam logic [3:0] ENV_TRI_UP       = 4'd14;
    localparam logic [3:0] ENV_ATTACK_ALT   = 4'd15;

    // Envelope level bounds (signed).
    localparam logic signed [6:0] ENV_LV_MIN  = -7'sd1;
    localparam logic signed [6:0] ENV_LV_ZERO = 7'sd0;
    localparam logic signed [6:0] ENV_LV_TOP  = 7'sd31;
    localparam logic signed [6:0] ENV_LV_MAX  = 7'sd32;

    // Noise shift register reset pattern.
    localparam logic [16:0] NOISE_SEED = 17'h0FFFF;

    // Fixed-volume tone periods at or below this force the tone gate high.
    localparam logic [11:0] TONE_SHORT_MAX = 12'd4;

    // Amplitude level table.
    localparam logic [15:0] LEVELS [16] = '{
        16'd0,     16'd836,   16'd1212,  16'd1773,
        16'd2619,  16'd3875,  16'd5397,  16'd8823,
        16'd10392, 16'd16706, 16'd23339, 16'd29292,
        16'd36969, 16'd46421, 16'd55195, 16'd65535
    };

endpackage

// ----- sv/psg_tone_noise_envelope_tick.sv -----
// ----------------------------------------------------------------------------
// PSG tone/noise/envelope tick core
// Three-voice sound generator: register writes and generator ticks arrive on
// one channel; each tick yields the three channel amplitudes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_in): a beat with mode 0 writes one of
//   fourteen sound registers (writes to 14 and 15 are dropped); a beat with
//   mode 1 is one generator tick. Writing the shape register restarts the
//   envelope.
//   Output channel (o_valid / i_stall / o_out): one beat per tick carrying
//   amp_a, amp_b and amp_c; register writes produce no output beat.
//   Latency: the output beat of a tick is valid in the cycle after the tick
//   is accepted. Throughput: one input beat per cycle while o_stall is low;
//   amplitudes are computed combinationally from state into the output register.
//   Stall: while an output beat waits with i_stall high, o_stall is raised
//   and no input beat is taken; as soon as the waiting beat is taken a new
//   input beat is accepted in the same cycle.
//   Reset (synchronous, i_rst_n low): all sound registers, dividers and the
//   envelope clear, the noise shift register loads 0xFFFF, and the output
//   register empties. The envelope holds at level 0 until the first shape
//   write.
// ----------------------------------------------------------------------------
`include "psg_tone_noise_envelope_tick_defines.svh"

module psg_tone_noise_envelope_tick
    import ptne_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_out
);

    // State registers.
    logic [7:0]         r_regs [NUM_REGS];
    logic [15:0]        r_tone_cnt [3];
    logic [2:0]         r_tone_out;
    logic [15:0]        r_noise_cnt;
    logic [16:0]        r_noise;
    logic [15:0]        r_env_cnt;
    logic signed [6:0]  r_env_lv;
    logic               r_env_fp;
    logic               r_out_valid;
    t_out_beat          r_out;

    // Next-state values.
    logic [15:0]        n_tone_cnt [3];
    logic [2:0]         n_tone_out;
    logic [15:0]        n_noise_cnt;
    logic [16:0]        n_noise;
    logic [15:0]        n_env_cnt;
    logic signed [6:0]  n_env_lv;
    logic               n_env_fp;
    t_out_beat          n_out;

    logic               in_accept;
    logic               is_tick;
    logic               is_write;
    logic [11:0]        tone_per [3];
    logic [4:0]         amp_reg [3];
    logic [15:0]        tone_inc [3];
    logic [15:0]        noise_inc;
    logic [15:0]        env_inc;
    logic [15:0]        env_per;
    logic signed [6:0]  lv_dec;
    logic signed [6:0]  lv_inc;
    logic signed [6:0]  step_lv;
    logic               step_fp;
    logic [15:0]        amp [3];
    logic               gate;
    logic [3:0]         env_idx;

    // Handshake: take a beat unless a waiting output beat is held back.
    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;
    assign is_tick   = in_accept & (i_in.mode == MODE_TICK);
    assign is_write  = in_accept & (i_in.mode == MODE_WRITE);
    assign o_valid   = r_out_valid;
    assign o_out     = r_out;

    // Register fields used by the generators.
    assign tone_per[0] = {r_regs[REG_TONE_A_HI][3:0], r_regs[REG_TONE_A_LO]};
    assign tone_per[1] = {r_regs[REG_TONE_B_HI][3:0], r_regs[REG_TONE_B_LO]};
    assign tone_per[2] = {r_regs[REG_TONE_C_HI][3:0], r_regs[REG_TONE_C_LO]};
    assign amp_reg[0]  = r_regs[REG_AMP_A][4:0];
    assign amp_reg[1]  = r_regs[REG_AMP_B][4:0];
    assign amp_reg[2]  = r_regs[REG_AMP_C][4:0];
    assign env_per     = {r_regs[REG_ENV_HI], r_regs[REG_ENV_LO]};

    // Tone dividers: count up, wrap and toggle once the period is reached.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            tone_inc[ch] = r_tone_cnt[ch] + 16'd1;
            if (tone_inc[ch] >= {4'd0, tone_per[ch]}) begin
                n_tone_cnt[ch] = '0;
                n_tone_out[ch] = ~r_tone_out[ch];
            end else begin
                n_tone_cnt[ch] = tone_inc[ch];
                n_tone_out[ch] = r_tone_out[ch];
            end
        end
    end

    // Noise divider: shifts the generator on even counts at twice the period.
    always_comb begin
        noise_inc = r_noise_cnt + 16'd1;
        if (!noise_inc[0] && (noise_inc >= {10'd0, r_regs[REG_NOISE_PER][4:0], 1'b0})) begin
            n_noise_cnt = '0;
            n_noise     = {r_noise[15:0], ~(r_noise[13] ^ r_noise[16])};
        end else begin
            n_noise_cnt = noise_inc;
            n_noise     = r_noise;
        end
    end

    // Envelope shape step.
    always_comb begin
        lv_dec  = r_env_lv - 7'sd1;
        lv_inc  = r_env_lv + 7'sd1;
        step_lv = r_env_lv;
        step_fp = r_env_fp;
        case (r_regs[REG_ENV_SHAPE][3:0]) inside
            [ENV_DECAY_FIRST:ENV_DECAY_LAST], ENV_DECAY_ALT: begin
                if (r_env_fp) begin
                    step_lv = lv_dec;
                    step_fp = (lv_dec != ENV_LV_ZERO);
                end
            end
            [ENV_ATTACK_FIRST:ENV_ATTACK_LAST], ENV_ATTACK_ALT: begin
                if (r_env_fp) begin
                    if (lv_inc == ENV_LV_MAX) begin
                        step_fp = 1'b0;
                        step_lv = ENV_LV_ZERO;
                    end else begin
                        step_lv = lv_inc;
                    end
                end
            end
            ENV_SAW_DOWN: begin
                step_lv = {2'b00, lv_dec[4:0]};
            end
            ENV_TRI_DOWN: begin
                if (r_env_fp) begin
                    if (lv_dec == ENV_LV_MIN) begin
                        step_fp = 1'b0;
                        step_lv = ENV_LV_ZERO;
                    end else begin
                        step_lv = lv_dec;
                    end
                end else if (lv_inc == ENV_LV_MAX) begin
                    step_fp = 1'b1;
                    step_lv = ENV_LV_TOP;
                end else begin
                    step_lv = lv_inc;
                end
            end
            ENV_DECAY_HIGH: begin
                if (r_env_fp) begin
                    if (lv_dec == ENV_LV_MIN) begin
                        step_fp = 1'b0;
                        step_lv = ENV_LV_TOP;
                    end else begin
                        step_lv = lv_dec;
                    end
                end
            end
            ENV_SAW_UP: begin
                step_lv = {2'b00, lv_inc[4:0]};
            end
            ENV_ATTACK_HOLD: begin
                if (r_env_fp) begin
                    if (lv_inc == ENV_LV_MAX) begin
                        step_fp = 1'b0;
                        step_lv = ENV_LV_TOP;
                    end else begin
                        step_lv = lv_inc;
                    end
                end
            end
            default: begin
                // Triangle starting upward.
                if (!r_env_fp) begin
                    if (lv_dec == ENV_LV_MIN) begin
                        step_fp = 1'b1;
                        step_lv = ENV_LV_ZERO;
                    end else begin
                        step_lv = lv_dec;
                    end
                end else if (lv_inc == ENV_LV_MAX) begin
                    step_fp = 1'b0;
                    step_lv = ENV_LV_TOP;
                end else begin
                    step_lv = lv_inc;
                end
            end
        endcase
        // Keep the level inside its legal range.
        if (step_lv < ENV_LV_MIN) begin
            step_lv = ENV_LV_MIN;
        end else if (step_lv > ENV_LV_MAX) begin
            step_lv = ENV_LV_MAX;
        end
    end

    // Envelope divider: the shape steps when the counter sits at zero.
    always_comb begin
        if (r_env_cnt == 16'd0) begin
            n_env_lv = step_lv;
            n_env_fp = step_fp;
        end else begin
            n_env_lv = r_env_lv;
            n_env_fp = r_env_fp;
        end
        env_inc   = r_env_cnt + 16'd1;
        n_env_cnt = (env_inc >= env_per) ? 16'd0 : env_inc;
    end

    // Mixer and level lookup, from the state after this tick.
    always_comb begin
        env_idx = n_env_lv[4:1];
        for (int ch = 0; ch < 3; ch++) begin
            if (r_regs[REG_MIXER][ch]) begin
                gate = 1'b1;
            end else if (!amp_reg[ch][4] && (tone_per[ch] <= TONE_SHORT_MAX)) begin
                gate = 1'b1;
            end else begin
                gate = n_tone_out[ch];
            end
            if (!r_regs[REG_MIXER][ch + 3]) begin
                gate = gate & n_noise[16];
            end
            if (!gate) begin
                amp[ch] = 16'd0;
            end else if (!amp_reg[ch][4]) begin
                amp[ch] = LEVELS[amp_reg[ch][3:0]];
            end else begin
                amp[ch] = LEVELS[env_idx];
            end
        end
        n_out.amp_a = amp[0];
        n_out.amp_b = amp[1];
        n_out.amp_c = amp[2];
    end

    // Sound registers with per-register write masks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (is_write) begin
            unique case (i_in.reg_number) inside
                REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI, REG_ENV_SHAPE: begin
                    r_regs[i_in.reg_number] <= i_in.reg_value & MASK_NIBBLE;
                end
                REG_NOISE_PER, REG_AMP_A, REG_AMP_B, REG_AMP_C: begin
                    r_regs[i_in.reg_number] <= i_in.reg_value & MASK_FIVE;
                end
                REG_MIXER: begin
                    r_regs[i_in.reg_number] <= i_in.reg_value & MASK_SIX;
                end
                REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO, REG_ENV_LO, REG_ENV_HI: begin
                    r_regs[i_in.reg_number] <= i_in.reg_value;
                end
                default: begin
                    // Unused register numbers are dropped.
                end
            endcase
        end
    end

    // Generator state: advances on a tick, the shape write restarts the envelope.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_tone_cnt[ch] <= '0;
            end
            r_tone_out  <= '0;
            r_noise_cnt <= '0;
            r_noise     <= NOISE_SEED;
            r_env_cnt   <= '0;
            r_env_lv    <= ENV_LV_ZERO;
            r_env_fp    <= 1'b0;
        end else if (is_tick) begin
            r_tone_cnt  <= n_tone_cnt;
            r_tone_out  <= n_tone_out;
            r_noise_cnt <= n_noise_cnt;
            r_noise     <= n_noise;
            r_env_cnt   <= n_env_cnt;
            r_env_lv    <= n_env_lv;
            r_env_fp    <= n_env_fp;
        end else if (is_write && (i_in.reg_number == REG_ENV_SHAPE)) begin
            r_env_cnt <= '0;
            r_env_fp  <= 1'b1;
            r_env_lv  <= i_in.reg_value[2] ? ENV_LV_MIN : ENV_LV_MAX;
        end
    end

    // Output register: loads on a tick, empties when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (is_tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_tick) begin
            r_out <= n_out;
        end
    end

    // Checks on the generator and output logic.
    `PTNE_ASSERT_NEXT(a_tick_gives_beat, is_tick, r_out_valid, "tick produced no output beat")
    `PTNE_ASSERT_NEXT(a_write_no_beat, is_write && (!r_out_valid || !i_stall), !r_out_valid, "register write produced an output beat")
    `PTNE_ASSERT_NOW(a_env_range, 1'b1, (r_env_lv >= ENV_LV_MIN) && (r_env_lv <= ENV_LV_MAX), "envelope level out of range")
    `PTNE_ASSERT_NEXT(a_shape_restart, is_write && (i_in.reg_number == REG_ENV_SHAPE), r_env_fp && (r_env_cnt == 16'd0), "shape write did not restart the envelope")
    `PTNE_ASSERT_NOW(a_stall_holds_input, r_out_valid && i_stall, !in_accept, "beat taken while output is held")

endmodule

// ----- tb/sv/psg_tone_noise_envelope_tick_checker.sv -----
// ----------------------------------------------------------------------------
// PSG tone/noise/envelope tick checker
// Watches both channels of the sound generator core, keeps its own model of
// the sound registers, dividers, noise shift register and envelope, and
// compares every output beat with the amplitudes predicted for the oldest
// outstanding tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module psg_tone_noise_envelope_tick_checker
    import ptne_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out,
    output int        o_fail_count,
    output int        o_pending
);

    // Model state, mirroring the generator's registers.
    logic [7:0]         sound_regs [NUM_REGS];
    logic [15:0]        tone_cnt [3];
    logic               tone_out [3];
    logic [15:0]        noise_cnt;
    logic [16:0]        noise_lfsr;
    logic [15:0]        env_cnt;
    logic signed [6:0]  env_level;
    logic               env_first;

    // Amplitudes predicted for ticks whose output beat has not arrived yet.
    t_out_beat expected_amps [$];
    int        ticks_checked;

    task automatic report_mismatch(input string what);
        $display("%0t ns: amplitude mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic logic [11:0] tone_period(input int ch);
        return {sound_regs[2 * ch + 1][3:0], sound_regs[2 * ch]};
    endfunction

    task automatic clear_model();
        for (int r = 0; r < NUM_REGS; r++) begin
            sound_regs[r] = 8'd0;
        end
        for (int ch = 0; ch < 3; ch++) begin
            tone_cnt[ch] = 16'd0;
            tone_out[ch] = 1'b0;
        end
        noise_cnt  = 16'd0;
        noise_lfsr = NOISE_SEED;
        env_cnt    = 16'd0;
        env_level  = ENV_LV_ZERO;
        env_first  = 1'b0;
        expected_amps.delete();
    endtask

    // Register write with per-register masking; the shape register restarts
    // the envelope from the top or from below zero depending on bit 2.
    task automatic store_register(input logic [3:0] num, input logic [7:0] val);
        case (num)
            REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI, REG_ENV_SHAPE: begin
                sound_regs[num] = val & MASK_NIBBLE;
            end
            REG_NOISE_PER, REG_AMP_A, REG_AMP_B, REG_AMP_C: begin
                sound_regs[num] = val & MASK_FIVE;
            end
            REG_MIXER: begin
                sound_regs[num] = val & MASK_SIX;
            end
            REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO, REG_ENV_LO, REG_ENV_HI: begin
                sound_regs[num] = val;
            end
            default: begin
                // Numbers past the register file are dropped.
            end
        endcase
        if (num == REG_ENV_SHAPE) begin
            env_cnt   = 16'd0;
            env_first = 1'b1;
            env_level = val[2] ? ENV_LV_MIN : ENV_LV_MAX;
        end
    endtask

    // One envelope step for the current shape.
    task automatic step_envelope();
        logic [3:0] shape;
        int         lv;
        logic       first;
        shape = sound_regs[REG_ENV_SHAPE][3:0];
        lv    = env_level;
        first = env_first;
        if (shape <= ENV_DECAY_LAST || shape == ENV_DECAY_ALT) begin
            if (first) begin
                lv--;
                if (lv == ENV_LV_ZERO) first = 1'b0;
            end
        end else if (shape <= ENV_ATTACK_LAST || shape == ENV_ATTACK_ALT) begin
            if (first) begin
                lv++;
                if (lv == ENV_LV_MAX) begin
                    first = 1'b0;
                    lv    = ENV_LV_ZERO;
                end
            end
        end else if (shape == ENV_SAW_DOWN) begin
            lv = (lv - 1) & ENV_LV_TOP;
        end else if (shape == ENV_TRI_DOWN) begin
            if (first) begin
                lv--;
                if (lv == ENV_LV_MIN) begin
                    first = 1'b0;
                    lv    = ENV_LV_ZERO;
                end
            end else begin
                lv++;
                if (lv == ENV_LV_MAX) begin
                    first = 1'b1;
                    lv    = ENV_LV_TOP;
                end
            end
        end else if (shape == ENV_DECAY_HIGH) begin
            if (first) begin
                lv--;
                if (lv == ENV_LV_MIN) begin
                    first = 1'b0;
                    lv    = ENV_LV_TOP;
                end
            end
        end else if (shape == ENV_SAW_UP) begin
            lv = (lv + 1) & ENV_LV_TOP;
        end else if (shape == ENV_ATTACK_HOLD) begin
            if (first) begin
                lv++;
                if (lv == ENV_LV_MAX) begin
                    first = 1'b0;
                    lv    = ENV_LV_TOP;
                end
            end
        end else begin
            // Triangle that starts upward.
            if (!first) begin
                lv--;
                if (lv == ENV_LV_MIN) begin
                    first = 1'b1;
                    lv    = ENV_LV_ZERO;
                end
            end else begin
                lv++;
                if (lv == ENV_LV_MAX) begin
                    first = 1'b0;
                    lv    = ENV_LV_TOP;
                end
            end
        end
        if (lv < ENV_LV_MIN) lv = ENV_LV_MIN;
        if (lv > ENV_LV_MAX) lv = ENV_LV_MAX;
        env_level = lv[6:0];
        env_first = first;
    endtask

    // One generator tick: advance dividers, noise and envelope, then gate
    // each channel's level.
    task automatic advance_tick(output t_out_beat amps);
        logic [15:0] env_period;
        logic [15:0] level [3];
        logic [5:0]  mixer;
        logic [4:0]  ampl;
        logic        fixed;
        logic        gate;
        logic        noise_bit;

        for (int ch = 0; ch < 3; ch++) begin
            tone_cnt[ch] = tone_cnt[ch] + 16'd1;
            if (tone_cnt[ch] >= {4'd0, tone_period(ch)}) begin
                tone_cnt[ch] = 16'd0;
                tone_out[ch] = ~tone_out[ch];
            end
        end

        noise_cnt = noise_cnt + 16'd1;
        if (!noise_cnt[0] &&
            noise_cnt >= {10'd0, sound_regs[REG_NOISE_PER][4:0], 1'b0}) begin
            noise_cnt  = 16'd0;
            noise_lfsr = {noise_lfsr[15:0], ~(noise_lfsr[13] ^ noise_lfsr[16])};
        end

        if (env_cnt == 16'd0) step_envelope();
        env_cnt    = env_cnt + 16'd1;
        env_period = {sound_regs[REG_ENV_HI], sound_regs[REG_ENV_LO]};
        if (env_cnt >= env_period) env_cnt = 16'd0;

        noise_bit = noise_lfsr[16];
        mixer     = sound_regs[REG_MIXER][5:0];
        for (int ch = 0; ch < 3; ch++) begin
            ampl  = sound_regs[REG_AMP_A + ch][4:0];
            fixed = !ampl[4];
            // Short fixed-volume tones are treated as a steady high gate.
            if (!mixer[ch]) begin
                gate = (fixed && tone_period(ch) <= TONE_SHORT_MAX) ? 1'b1 : tone_out[ch];
            end else begin
                gate = 1'b1;
            end
            if (!mixer[3 + ch]) gate = gate & noise_bit;
            if (!gate) begin
                level[ch] = 16'd0;
            end else if (fixed) begin
                level[ch] = LEVELS[ampl[3:0]];
            end else begin
                level[ch] = LEVELS[env_level[4:1]];
            end
        end
        amps.amp_a = level[0];
        amps.amp_b = level[1];
        amps.amp_c = level[2];
    endtask

    task automatic check_amps(input t_out_beat got);
        t_out_beat want;
        if (expected_amps.size() == 0) begin
            report_mismatch($sformatf("beat a/b/c %0d/%0d/%0d with no tick outstanding",
                                      got.amp_a, got.amp_b, got.amp_c));
        end else begin
            want = expected_amps.pop_front();
            if (got.amp_a !== want.amp_a || got.amp_b !== want.amp_b ||
                got.amp_c !== want.amp_c) begin
                report_mismatch($sformatf("tick %0d: got a/b/c %0d/%0d/%0d, want %0d/%0d/%0d",
                                          ticks_checked, got.amp_a, got.amp_b, got.amp_c,
                                          want.amp_a, want.amp_b, want.amp_c));
            end
            ticks_checked++;
        end
    endtask

    // Output beats are checked before the input beat of the same edge is
    // applied; the queue keeps them in order either way.
    always @(posedge i_clk) begin : watch
        t_out_beat amps;
        if (!i_rst_n) begin
            clear_model();
            o_fail_count = 0;
            ticks_checked = 0;
        end else begin
            if (i_out_valid && !i_out_stall) check_amps(i_out);
            if (i_in_valid && !i_in_stall) begin
                if (i_in.mode == MODE_TICK) begin
                    advance_tick(amps);
                    expected_amps.push_back(amps);
                end else begin
                    store_register(i_in.reg_number, i_in.reg_value);
                end
            end
        end
        o_pending <= expected_amps.size();
    end

endmodule

// ----- tb/sv/psg_tone_noise_envelope_tick_tb.sv -----
// ----------------------------------------------------------------------------
// PSG tone/noise/envelope tick testbench
// Drives register writes and generator ticks into the sound generator core
// with random gaps and output back-pressure; a checker beside the core
// predicts every amplitude beat and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module psg_tone_noise_envelope_tick_tb;
    import ptne_pkg::*;

    localparam int ITEM_TARGET = 550;

    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_stall = 1'b0;
    t_in_beat  in_beat  = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;
    int        fail_count;
    int        pending;

    // Run bookkeeping kept by the sender; the receiver reads items_done.
    int items_done   = 0;
    int writes_sent  = 0;
    int ticks_sent   = 0;
    int restarts     = 0;
    int stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    psg_tone_noise_envelope_tick uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_in    (in_beat),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_out   (out_beat)
    );

    psg_tone_noise_envelope_tick_checker amp_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one beat, with an occasional idle gap ahead of it, and wait
    // until the core takes it.
    task automatic send_beat(input t_in_beat beat);
        logic calm;
        calm = items_done >= 150 && items_done < 260;
        if (!calm && $urandom_range(0, 99) < 30) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do begin
            @(posedge i_clk);
            if (in_stall) stall_cycles++;
        end while (in_stall);
        if (beat.mode == MODE_TICK) begin
            ticks_sent++;
        end else begin
            writes_sent++;
            if (beat.reg_number == REG_ENV_SHAPE) restarts++;
        end
        if (!(beat.mode == MODE_WRITE && beat.reg_number >= NUM_REGS)) items_done++;
    endtask

    task automatic write_reg(input logic [3:0] num, input logic [7:0] val);
        t_in_beat beat;
        beat.mode       = MODE_WRITE;
        beat.reg_number = num;
        beat.reg_value  = val;
        send_beat(beat);
    endtask

    // Ticks carry random don't-care register fields.
    task automatic run_ticks(input int count);
        t_in_beat beat;
        for (int k = 0; k < count; k++) begin
            beat.mode       = MODE_TICK;
            beat.reg_number = 4'($urandom);
            beat.reg_value  = 8'($urandom);
            send_beat(beat);
        end
    endtask

    // Stop offering and wait for every outstanding amplitude beat.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Register contents biased toward short periods so that tones, noise and
    // envelope all move within a burst of ticks.
    function automatic logic [7:0] pick_value(input logic [3:0] num);
        case (num)
            REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO: begin
                return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
            end
            REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: begin
                return ($urandom_range(0, 7) == 0) ? 8'($urandom) : {4'($urandom), 4'd0};
            end
            REG_ENV_LO: begin
                return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            end
            REG_ENV_HI: begin
                return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0;
            end
            default: begin
                return 8'($urandom);
            end
        endcase
    endfunction

    // Receiver: random stalls, a calm stretch, and one long hold-off while
    // the sender keeps offering beats.
    initial begin : receiver
        int  hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!hold_done && items_done >= 450) begin
                hold_done = 1'b1;
                hold_left = 59;
                out_stall <= 1'b1;
            end else if (items_done >= 330 && items_done < 430) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < 31);
            end
        end
    end

    // Sender: directed opening, then random register phrases with bursts of
    // ticks, and the verdict.
    initial begin : sender
        logic [3:0] num;
        logic       paused_mid;
        paused_mid = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Tick with everything at reset, then unused register numbers.
        run_ticks(1);
        write_reg(4'd15, 8'hFF);
        write_reg(4'd14, 8'h00);
        // All gates forced open; fixed full level and two envelope channels.
        write_reg(REG_MIXER, 8'hFF);
        write_reg(REG_AMP_A, 8'h0F);
        write_reg(REG_AMP_B, 8'h10);
        write_reg(REG_AMP_C, 8'hFF);
        run_ticks(1);
        // Restart from the top, then from below zero.
        write_reg(REG_ENV_SHAPE, 8'h00);
        run_ticks(1);
        write_reg(REG_ENV_SHAPE, 8'hFF);
        run_ticks(1);
        // Short fixed-volume tone with tone and noise enabled.
        write_reg(REG_TONE_A_LO, 8'h03);
        write_reg(REG_TONE_A_HI, 8'h00);
        write_reg(REG_MIXER, 8'h00);
        run_ticks(1);
        // Longest tone and noise periods, zero envelope period.
        write_reg(REG_TONE_B_LO, 8'hFF);
        write_reg(REG_TONE_B_HI, 8'hFF);
        write_reg(REG_NOISE_PER, 8'hFF);
        write_reg(REG_ENV_LO, 8'h00);
        write_reg(REG_ENV_HI, 8'h00);
        run_ticks(2);
        write_reg(REG_ENV_SHAPE, 8'h0A);
        run_ticks(2);
        drain();

        while (items_done < ITEM_TARGET) begin
            if (!paused_mid && items_done >= 300) begin
                paused_mid = 1'b1;
                drain();
            end
            if ($urandom_range(0, 99) < 8) begin
                write_reg(4'($urandom), 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    num = 4'($urandom_range(0, NUM_REGS - 1));
                    write_reg(num, pick_value(num));
                end
                if ($urandom_range(0, 3) == 0) write_reg(REG_ENV_SHAPE, 8'($urandom));
                run_ticks($urandom_range(4, 40));
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d ticks checked and %0d register writes (%0d envelope restarts).",
                 ticks_sent, writes_sent, restarts);
        $display("Input held off by output back-pressure on %0d cycles.", stall_cycles);
        if (fail_count == 0) begin
            $display("psg_tone_noise_envelope_tick_tb: PASS");
        end else begin
            $display("psg_tone_noise_envelope_tick_tb: FAIL");
        end
        $finish;
    end

    // Run limit.
    initial begin : watchdog
        #2000000;
        $display("psg_tone_noise_envelope_tick_tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/ptne_pkg.sv
sv/psg_tone_noise_envelope_tick.sv
tb/sv/psg_tone_noise_envelope_tick_checker.sv
tb/sv/psg_tone_noise_envelope_tick_tb.sv
